>>> design/scm_pkg.sv
// Shared constants, codes and the controller-to-datapath command for the correlation meter.
package scm_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int COEFF_BITS  = 24;
   localparam int OUT_BITS    = 16;
   localparam int FUNC_BITS   = 2;

   localparam int PROD_BITS = 2 * SAMPLE_BITS;            // one smoothed average
   localparam int HALF_BITS = SAMPLE_BITS;                // multiplier operand slice
   localparam int MUL_BITS  = HALF_BITS + 2;              // signed operand, holds 2^COEFF_BITS
   localparam int ACC_BITS  = 2 * PROD_BITS;              // widest partial-product sum
   localparam int QUO_BITS  = OUT_BITS - 1;               // correlation magnitude
   localparam int FRAC_BITS = 2 * QUO_BITS;
   localparam int ROOT_BITS = 2 * PROD_BITS + FRAC_BITS;  // root/divide remainder

   localparam logic [COEFF_BITS-1:0] COEFF_RESET =
      COEFF_BITS'(((longint'(1) << COEFF_BITS) * 9999) / 10000);

   // sequencer step map
   localparam int STEP_BITS = 6;
   localparam logic [STEP_BITS-1:0] STEP_EMA       = 6'd3;
   localparam logic [STEP_BITS-1:0] STEP_SQR       = STEP_EMA + 6'd12;
   localparam logic [STEP_BITS-1:0] STEP_ISSUE_END = STEP_SQR + 6'd8;
   localparam logic [STEP_BITS-1:0] STEP_ROOT      = STEP_ISSUE_END + 6'd2;
   localparam logic [STEP_BITS-1:0] STEP_FINAL     = STEP_ROOT + STEP_BITS'(2 * QUO_BITS);
   localparam logic [STEP_BITS-1:0] STEP_CMT_XP    = 6'd2;
   localparam logic [STEP_BITS-1:0] STEP_CMT_XL    = 6'd3;
   localparam logic [STEP_BITS-1:0] STEP_CMT_XR    = 6'd4;
   localparam logic [STEP_BITS-1:0] STEP_CMT_AVGP  = STEP_EMA + 6'd5;
   localparam logic [STEP_BITS-1:0] STEP_CMT_AVGL  = STEP_EMA + 6'd9;
   localparam logic [STEP_BITS-1:0] STEP_CMT_AVGR  = STEP_EMA + 6'd13;
   localparam logic [STEP_BITS-1:0] STEP_CMT_SQ    = STEP_SQR + 6'd5;
   localparam logic [STEP_BITS-1:0] STEP_CMT_LR    = STEP_SQR + 6'd9;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_PROCESS = 2'd0,
      FUNC_SAVE    = 2'd1,
      FUNC_RESTORE = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } ctrl_state_type;

   typedef enum logic [3:0] {
      MUL_L_R,
      MUL_L_L,
      MUL_R_R,
      MUL_C_OL,
      MUL_C_OH,
      MUL_D_XL,
      MUL_D_XH,
      MUL_P_LL,
      MUL_P_LH,
      MUL_P_HL,
      MUL_P_HH,
      MUL_E_LL,
      MUL_E_LH,
      MUL_E_HL,
      MUL_E_HH
   } mul_op_type;

   typedef enum logic [1:0] {
      AVG_P,
      AVG_L,
      AVG_R
   } avg_sel_type;

   typedef enum logic [2:0] {
      DST_XP,
      DST_XL,
      DST_XR,
      DST_AVGP,
      DST_AVGL,
      DST_AVGR,
      DST_SQ,
      DST_LR
   } dst_type;

   typedef struct packed {
      logic        load;
      logic        save;
      logic        restore;
      logic        quiet;
      logic        issue;
      logic        clear;
      mul_op_type  op;
      avg_sel_type src;
      logic        commit;
      dst_type     dst;
      logic        root_a;
      logic        root_b;
      logic        finalize;
      logic        emit;
   } dp_cmd_type;

endpackage

>>> design/scm_ctrl.sv
// Sequencer for the correlation meter: accepts words and steps the datapath.
module scm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic [scm_pkg::FUNC_BITS-1:0] req_func,
   input  logic                          out_free,
   output logic                          req_tready,
   output scm_pkg::dp_cmd_type           cmd
);

   scm_pkg::ctrl_state_type state_ff, state_in;
   logic [scm_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic [scm_pkg::STEP_BITS-1:0] rel;
   logic [1:0] slot;
   scm_pkg::func_type func;

   assign func = scm_pkg::func_type'(req_func);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scm_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         scm_pkg::ST_IDLE: begin
            step_in = '0;
            if (req_tvalid) begin
               if (func == scm_pkg::FUNC_PROCESS) state_in = scm_pkg::ST_RUN;
               else state_in = scm_pkg::ST_FINISH;
            end
         end
         scm_pkg::ST_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == scm_pkg::STEP_FINAL) state_in = scm_pkg::ST_FINISH;
         end
         scm_pkg::ST_FINISH: begin
            if (out_free) state_in = scm_pkg::ST_IDLE;
         end
         default: state_in = scm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rel        = '0;
      slot       = '0;
      case (state_ff)
         scm_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load    = req_tvalid;
            cmd.save    = req_tvalid && (func == scm_pkg::FUNC_SAVE);
            cmd.restore = req_tvalid && (func == scm_pkg::FUNC_RESTORE);
            cmd.quiet   = req_tvalid && (func != scm_pkg::FUNC_PROCESS);
         end
         scm_pkg::ST_RUN: begin
            // sample products
            if (step_ff < scm_pkg::STEP_EMA) begin
               cmd.issue = 1'b1;
               cmd.clear = 1'b1;
               case (step_ff[1:0])
                  2'd0:    cmd.op = scm_pkg::MUL_L_R;
                  2'd1:    cmd.op = scm_pkg::MUL_L_L;
                  default: cmd.op = scm_pkg::MUL_R_R;
               endcase
            // three smoothing updates, four partial products each
            end else if (step_ff < scm_pkg::STEP_SQR) begin
               rel       = step_ff - scm_pkg::STEP_EMA;
               slot      = rel[1:0];
               cmd.issue = 1'b1;
               cmd.clear = (slot == 2'd0);
               cmd.src   = scm_pkg::avg_sel_type'(rel[3:2]);
               case (slot)
                  2'd0:    cmd.op = scm_pkg::MUL_C_OL;
                  2'd1:    cmd.op = scm_pkg::MUL_C_OH;
                  2'd2:    cmd.op = scm_pkg::MUL_D_XL;
                  default: cmd.op = scm_pkg::MUL_D_XH;
               endcase
            // product squared, then energy product
            end else if (step_ff < scm_pkg::STEP_ISSUE_END) begin
               rel       = step_ff - scm_pkg::STEP_SQR;
               slot      = rel[1:0];
               cmd.issue = 1'b1;
               cmd.clear = (slot == 2'd0);
               case ({rel[2], slot})
                  3'd0:    cmd.op = scm_pkg::MUL_P_LL;
                  3'd1:    cmd.op = scm_pkg::MUL_P_LH;
                  3'd2:    cmd.op = scm_pkg::MUL_P_HL;
                  3'd3:    cmd.op = scm_pkg::MUL_P_HH;
                  3'd4:    cmd.op = scm_pkg::MUL_E_LL;
                  3'd5:    cmd.op = scm_pkg::MUL_E_LH;
                  3'd6:    cmd.op = scm_pkg::MUL_E_HL;
                  default: cmd.op = scm_pkg::MUL_E_HH;
               endcase
            end

            // accumulator results are committed once the last issue has passed the product and accumulator registers
            case (step_ff)
               scm_pkg::STEP_CMT_XP: begin
                  cmd.commit = 1'b1;
                  cmd.dst    = scm_pkg::DST_XP;
               end
               scm_pkg::STEP_CMT_XL: begin
                  cmd.commit = 1'b1;
                  cmd.dst    = scm_pkg::DST_XL;
               end
               scm_pkg::STEP_CMT_XR: begin
                  cmd.commit = 1'b1;
                  cmd.dst    = scm_pkg::DST_XR;
               end
               scm_pkg::STEP_CMT_AVGP: begin
                  cmd.commit = 1'b1;
                  cmd.dst    = scm_pkg::DST_AVGP;
               end
               scm_pkg::STEP_CMT_AVGL: begin
                  cmd.commit = 1'b1;
                  cmd.dst    = scm_pkg::DST_AVGL;
               end
               scm_pkg::STEP_CMT_AVGR: begin
                  cmd.commit = 1'b1;
                  cmd.dst    = scm_pkg::DST_AVGR;
               end
               scm_pkg::STEP_CMT_SQ: begin
                  cmd.commit = 1'b1;
                  cmd.dst    = scm_pkg::DST_SQ;
               end
               scm_pkg::STEP_CMT_LR: begin
                  cmd.commit = 1'b1;
                  cmd.dst    = scm_pkg::DST_LR;
               end
               default: cmd.commit = 1'b0;
            endcase

            if (step_ff >= scm_pkg::STEP_ROOT && step_ff < scm_pkg::STEP_FINAL) begin
               cmd.root_a = (step_ff[0] == scm_pkg::STEP_ROOT[0]);
               cmd.root_b = (step_ff[0] != scm_pkg::STEP_ROOT[0]);
            end
            cmd.finalize = (step_ff == scm_pkg::STEP_FINAL);
         end
         scm_pkg::ST_FINISH: begin
            cmd.emit = out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

>>> design/scm_dp.sv
// Datapath: shared multiplier and accumulator, smoothed averages, root/divide unit.
module scm_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  scm_pkg::dp_cmd_type                   cmd,
   input  logic signed [scm_pkg::SAMPLE_BITS-1:0] left,
   input  logic signed [scm_pkg::SAMPLE_BITS-1:0] right,
   input  logic [scm_pkg::COEFF_BITS-1:0]        coeff,
   output logic signed [scm_pkg::OUT_BITS-1:0]   correlation,
   output logic                                  silent
);

   localparam int SB = scm_pkg::SAMPLE_BITS;
   localparam int CB = scm_pkg::COEFF_BITS;
   localparam int PB = scm_pkg::PROD_BITS;
   localparam int HB = scm_pkg::HALF_BITS;
   localparam int MW = scm_pkg::MUL_BITS;
   localparam int AW = scm_pkg::ACC_BITS;
   localparam int RW = scm_pkg::ROOT_BITS;
   localparam int QB = scm_pkg::QUO_BITS;
   localparam int OB = scm_pkg::OUT_BITS;
   localparam int FB = scm_pkg::FRAC_BITS;
   localparam logic [PB-1:0] P_MSB = {1'b1, {(PB-1){1'b0}}};

   // captured samples and per-sample products
   logic signed [SB-1:0] left_ff, right_ff;
   logic [PB-1:0] xp_ff, xl_ff, xr_ff;

   // architectural state
   logic [PB-1:0] avg_p_ff, avg_l_ff, avg_r_ff;
   logic [PB-1:0] sav_p_ff, sav_l_ff, sav_r_ff;
   logic signed [OB-1:0] corr_ff;
   logic silent_ff;

   logic [PB-1:0] pabs_ff;
   logic neg_ff;

   // multiplier / accumulator pipe
   logic signed [MW-1:0] a_op, b_op;
   logic signed [2*MW-1:0] prod_in, prod_ff;
   logic [1:0] sh_in, sh_ff;
   logic clr_ff, mac_ff;
   logic [AW-1:0] acc_ff, acc_in, addend;
   logic signed [AW-1:0] prod_ext;

   // root/divide unit
   logic [RW-1:0] rem_ff, dsr_ff, wacc_ff, inc_ff;
   logic [RW:0] diff;
   logic fit;
   logic [QB-1:0] q_ff;

   logic [CB:0] coef_d;
   logic [PB-1:0] o_val, x_val, ema_res, new_p;
   logic [OB-1:0] q_ext;

   assign coef_d = {1'b1, {CB{1'b0}}} - {1'b0, coeff};

   always_comb begin
      case (cmd.src)
         scm_pkg::AVG_P: begin
            o_val = avg_p_ff ^ P_MSB;   // bias to unsigned
            x_val = xp_ff ^ P_MSB;
         end
         scm_pkg::AVG_L: begin
            o_val = avg_l_ff;
            x_val = xl_ff;
         end
         scm_pkg::AVG_R: begin
            o_val = avg_r_ff;
            x_val = xr_ff;
         end
         default: begin
            o_val = '0;
            x_val = '0;
         end
      endcase
   end

   always_comb begin
      sh_in = 2'd0;
      case (cmd.op)
         scm_pkg::MUL_L_R: begin
            a_op = MW'(left_ff);
            b_op = MW'(right_ff);
         end
         scm_pkg::MUL_L_L: begin
            a_op = MW'(left_ff);
            b_op = MW'(left_ff);
         end
         scm_pkg::MUL_R_R: begin
            a_op = MW'(right_ff);
            b_op = MW'(right_ff);
         end
         scm_pkg::MUL_C_OL: begin
            a_op = MW'(coeff);
            b_op = MW'(o_val[HB-1:0]);
         end
         scm_pkg::MUL_C_OH: begin
            a_op  = MW'(coeff);
            b_op  = MW'(o_val[PB-1:HB]);
            sh_in = 2'd1;
         end
         scm_pkg::MUL_D_XL: begin
            a_op = MW'(coef_d);
            b_op = MW'(x_val[HB-1:0]);
         end
         scm_pkg::MUL_D_XH: begin
            a_op  = MW'(coef_d);
            b_op  = MW'(x_val[PB-1:HB]);
            sh_in = 2'd1;
         end
         scm_pkg::MUL_P_LL: begin
            a_op = MW'(pabs_ff[HB-1:0]);
            b_op = MW'(pabs_ff[HB-1:0]);
         end
         scm_pkg::MUL_P_LH: begin
            a_op  = MW'(pabs_ff[HB-1:0]);
            b_op  = MW'(pabs_ff[PB-1:HB]);
            sh_in = 2'd1;
         end
         scm_pkg::MUL_P_HL: begin
            a_op  = MW'(pabs_ff[PB-1:HB]);
            b_op  = MW'(pabs_ff[HB-1:0]);
            sh_in = 2'd1;
         end
         scm_pkg::MUL_P_HH: begin
            a_op  = MW'(pabs_ff[PB-1:HB]);
            b_op  = MW'(pabs_ff[PB-1:HB]);
            sh_in = 2'd2;
         end
         scm_pkg::MUL_E_LL: begin
            a_op = MW'(avg_l_ff[HB-1:0]);
            b_op = MW'(avg_r_ff[HB-1:0]);
         end
         scm_pkg::MUL_E_LH: begin
            a_op  = MW'(avg_l_ff[HB-1:0]);
            b_op  = MW'(avg_r_ff[PB-1:HB]);
            sh_in = 2'd1;
         end
         scm_pkg::MUL_E_HL: begin
            a_op  = MW'(avg_l_ff[PB-1:HB]);
            b_op  = MW'(avg_r_ff[HB-1:0]);
            sh_in = 2'd1;
         end
         scm_pkg::MUL_E_HH: begin
            a_op  = MW'(avg_l_ff[PB-1:HB]);
            b_op  = MW'(avg_r_ff[PB-1:HB]);
            sh_in = 2'd2;
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
   end

   assign prod_in = a_op * b_op;

   always_comb begin
      prod_ext = AW'(prod_ff);
      case (sh_ff)
         2'd1:    addend = prod_ext << HB;
         2'd2:    addend = prod_ext << (2 * HB);
         default: addend = prod_ext;
      endcase
      acc_in = (clr_ff ? '0 : acc_ff) + addend;
   end

   assign ema_res = acc_ff[CB +: PB];
   assign new_p   = ema_res ^ P_MSB;

   assign diff  = {1'b0, rem_ff} - {1'b0, inc_ff};
   assign fit   = !diff[RW];
   assign q_ext = OB'(q_ff);

   // state with a defined reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_p_ff  <= '0;
         avg_l_ff  <= '0;
         avg_r_ff  <= '0;
         sav_p_ff  <= '0;
         sav_l_ff  <= '0;
         sav_r_ff  <= '0;
         corr_ff   <= '0;
         silent_ff <= 1'b0;
         mac_ff    <= 1'b0;
      end else begin
         mac_ff <= cmd.issue;
         if (cmd.save) begin
            sav_p_ff <= avg_p_ff;
            sav_l_ff <= avg_l_ff;
            sav_r_ff <= avg_r_ff;
         end
         if (cmd.restore) begin
            avg_p_ff <= sav_p_ff;
            avg_l_ff <= sav_l_ff;
            avg_r_ff <= sav_r_ff;
         end
         if (cmd.quiet) silent_ff <= 1'b0;
         if (cmd.commit) begin
            case (cmd.dst)
               scm_pkg::DST_AVGP: avg_p_ff  <= new_p;
               scm_pkg::DST_AVGL: avg_l_ff  <= ema_res;
               scm_pkg::DST_AVGR: avg_r_ff  <= ema_res;
               scm_pkg::DST_LR:   silent_ff <= (acc_ff == '0);
               default: ;
            endcase
         end
         if (cmd.finalize) begin
            if (silent_ff) corr_ff <= '0;
            else if (neg_ff) corr_ff <= -q_ext;
            else corr_ff <= q_ext;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_ff  <= left;
         right_ff <= right;
      end
      if (cmd.issue) begin
         prod_ff <= prod_in;
         sh_ff   <= sh_in;
         clr_ff  <= cmd.clear;
      end
      if (mac_ff) acc_ff <= acc_in;
      if (cmd.commit) begin
         case (cmd.dst)
            scm_pkg::DST_XP: xp_ff <= acc_ff[PB-1:0];
            scm_pkg::DST_XL: xl_ff <= acc_ff[PB-1:0];
            scm_pkg::DST_XR: xr_ff <= acc_ff[PB-1:0];
            scm_pkg::DST_AVGP: begin
               neg_ff  <= new_p[PB-1];
               pabs_ff <= new_p[PB-1] ? -new_p : new_p;
            end
            scm_pkg::DST_SQ: rem_ff <= RW'(acc_ff) << FB;
            scm_pkg::DST_LR: begin
               dsr_ff  <= RW'(acc_ff) << (FB - 2);
               wacc_ff <= '0;
               q_ff    <= '0;
            end
            default: ;
         endcase
      end
      if (cmd.root_a) inc_ff <= wacc_ff + dsr_ff;
      if (cmd.root_b) begin
         if (fit) rem_ff <= diff[RW-1:0];
         wacc_ff <= (wacc_ff >> 1) + (fit ? dsr_ff : '0);
         dsr_ff  <= dsr_ff >> 2;
         q_ff    <= {q_ff[QB-2:0], fit};
      end
   end

   assign correlation = corr_ff;
   assign silent      = silent_ff;

endmodule

>>> design/stereo_correlation_meter_core.sv
// Top level of the stereo phase correlation meter: ports, register, result stage.
//
//   channel | dir | handshake                  | contents
//   req     | in  | req_tvalid / req_tready    | tdata: left, right; tuser: func
//   rsp     | out | rsp_tvalid / rsp_tready    | tdata: correlation; tuser: silent
//   csr     | in  | csr_wr_en (no backpressure)| smooth_coeff
//
// A sample word runs through the sequencer steps (23 products through one shared
// 26x26 multiplier, then 15 restoring steps of the square-root/divide unit on a
// 126-bit remainder) between accept and hand-off. Save, restore and unused func
// words go straight from accept to hand-off.
// One word is in work at a time; the next is taken while a result still waits.
// A stalled rsp side holds the sequencer in its hand-off state only once the
// result register is still full. Reset is synchronous; averages and snapshot
// clear to zero, smooth_coeff returns to 0.9999.
module stereo_correlation_meter_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [2*scm_pkg::SAMPLE_BITS-1:0] req_tdata,  // left, right
   input  logic [scm_pkg::FUNC_BITS-1:0]  req_tuser,     // func
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [scm_pkg::OUT_BITS-1:0]   rsp_tdata,     // correlation
   output logic                           rsp_tuser,     // silent
   input  logic                           csr_wr_en,
   input  logic [scm_pkg::COEFF_BITS-1:0] csr_wr_data    // smooth_coeff
);

   localparam int SB = scm_pkg::SAMPLE_BITS;
   localparam logic [scm_pkg::OUT_BITS-1:0] CORR_MIN =
      {1'b1, {(scm_pkg::OUT_BITS-1){1'b0}}};

   logic [scm_pkg::COEFF_BITS-1:0] coeff_ff;
   logic rsp_valid_ff;
   logic [scm_pkg::OUT_BITS-1:0] rsp_data_ff;
   logic rsp_user_ff;
   logic out_free;
   scm_pkg::dp_cmd_type cmd;
   logic signed [scm_pkg::OUT_BITS-1:0] correlation;
   logic silent;

   // smoothing coefficient; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) coeff_ff <= scm_pkg::COEFF_RESET;
      else if (csr_wr_en) coeff_ff <= csr_wr_data;
   end

   // result register decouples the sequencer from the rsp side
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= correlation;
         rsp_user_ff <= silent;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   scm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .out_free   (out_free),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   scm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .left        (req_tdata[SB-1:0]),
      .right       (req_tdata[2*SB-1:SB]),
      .coeff       (coeff_ff),
      .correlation (correlation),
      .silent      (silent)
   );

`ifndef SYNTHESIS
   // a silent result always carries zero correlation
   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("silent word with nonzero correlation");

   // magnitude saturates at full scale minus one lsb
   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != CORR_MIN)
      else $error("correlation reached negative full scale");

   // one word in work at a time
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted a word while busy");

   // hand-off never overwrites an untaken result
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");
`endif

endmodule

>>> dv/tb.sv
// Self-checking testbench for the stereo correlation meter core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Receiver hold-off that backs the core up, and the no-progress limit of the watchdog
   localparam int HOLD_CYCLES  = 400;
   localparam int STUCK_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_WORDS  = 98;

   localparam logic signed [scm_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [scm_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

   typedef struct {
      logic [scm_pkg::OUT_BITS-1:0] corr;
      logic                         silent;
   } meter_reading_type;

   // How the right channel relates to the left within one run of random words
   typedef enum int {
      PAIR_FREE,
      PAIR_SAME,
      PAIR_INVERT,
      PAIR_SCALED,
      PAIR_NEAR,
      PAIR_LEFT_ONLY
   } pair_kind_type;

   // ------------------------------------------------------------------
   // Scoreboard: bit-exact copy of the meter state plus the expected queue
   // ------------------------------------------------------------------
   class meter_scoreboard;
      logic [scm_pkg::COEFF_BITS-1:0]       coeff;
      logic signed [scm_pkg::PROD_BITS-1:0] avg_prod, saved_prod;
      logic [scm_pkg::PROD_BITS-1:0]        avg_l, avg_r, saved_l, saved_r;
      logic [scm_pkg::OUT_BITS-1:0]         last_corr;
      meter_reading_type                    expected_readings[$];
      int errors, checked;
      int n_pairs, n_saves, n_restores, n_unused, n_silent, n_full_scale, n_negative;

      function new();
         coeff      = scm_pkg::COEFF_RESET;
         avg_prod   = '0;
         avg_l      = '0;
         avg_r      = '0;
         saved_prod = '0;
         saved_l    = '0;
         saved_r    = '0;
         last_corr  = '0;
      endfunction

      // floor((c*old + (2^24 - c)*new) / 2^24), all unsigned
      function logic [scm_pkg::PROD_BITS-1:0] smooth_avg(
            logic [scm_pkg::PROD_BITS-1:0] old_v,
            logic [scm_pkg::PROD_BITS-1:0] new_v);
         logic [79:0] acc;
         acc = {56'b0, coeff} * {32'b0, old_v}
             + ({55'b0, 25'h1000000} - {56'b0, coeff}) * {32'b0, new_v};
         return acc[71:24];
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      function void note_word(scm_pkg::func_type f,
                              logic signed [scm_pkg::SAMPLE_BITS-1:0] l,
                              logic signed [scm_pkg::SAMPLE_BITS-1:0] r);
         logic signed [scm_pkg::PROD_BITS-1:0] prod, sq_l, sq_r;
         logic [scm_pkg::PROD_BITS-1:0]        tmp, mag;
         logic [95:0]                          lr;
         logic [127:0]                         rhs, lhs;
         logic [scm_pkg::QUO_BITS-1:0]         q, t;
         meter_reading_type                    rd;
         rd.silent = 1'b0;
         case (f)
            scm_pkg::FUNC_PROCESS: begin
               n_pairs++;
               prod = l * r;
               sq_l = l * l;
               sq_r = r * r;
               // product average runs offset by 2^47: flipping the top bit adds the bias
               tmp = smooth_avg({~avg_prod[47], avg_prod[46:0]}, {~prod[47], prod[46:0]});
               avg_prod = {~tmp[47], tmp[46:0]};
               avg_l = smooth_avg(avg_l, sq_l);
               avg_r = smooth_avg(avg_r, sq_r);
               if (avg_l == '0 || avg_r == '0) begin
                  rd.silent = 1'b1;
                  last_corr = '0;
               end else begin
                  // largest q with q^2 * L * R <= P^2 * 2^30
                  mag = avg_prod[47] ? scm_pkg::PROD_BITS'(-avg_prod)
                                     : scm_pkg::PROD_BITS'(avg_prod);
                  lr  = {48'b0, avg_l} * {48'b0, avg_r};
                  rhs = ({80'b0, mag} * {80'b0, mag}) << 30;
                  q   = '0;
                  for (int b = scm_pkg::QUO_BITS - 1; b >= 0; b--) begin
                     t   = q | (scm_pkg::QUO_BITS'(1) << b);
                     lhs = {32'b0, lr} * ({113'b0, t} * {113'b0, t});
                     if (lhs <= rhs)
                        q = t;
                  end
                  last_corr = avg_prod[47] ? -{1'b0, q} : {1'b0, q};
               end
            end
            scm_pkg::FUNC_SAVE: begin
               n_saves++;
               saved_prod = avg_prod;
               saved_l    = avg_l;
               saved_r    = avg_r;
            end
            scm_pkg::FUNC_RESTORE: begin
               n_restores++;
               avg_prod = saved_prod;
               avg_l    = saved_l;
               avg_r    = saved_r;
            end
            default: n_unused++;
         endcase
         rd.corr = last_corr;
         if (rd.silent)
            n_silent++;
         if (rd.corr == 16'h7FFF || rd.corr == 16'h8001)
            n_full_scale++;
         if (rd.corr[scm_pkg::OUT_BITS-1])
            n_negative++;
         expected_readings.push_back(rd);
      endfunction

      function void check_word(logic [scm_pkg::OUT_BITS-1:0] corr, logic silent);
         meter_reading_type rd;
         if (expected_readings.size() == 0) begin
            errors++;
            $display("%0t: unexpected word corr=%0d silent=%0b", $time, $signed(corr), silent);
            return;
         end
         rd = expected_readings.pop_front();
         checked++;
         if (corr !== rd.corr) begin
            errors++;
            $display("%0t: correlation mismatch, expected %0d actual %0d",
                     $time, $signed(rd.corr), $signed(corr));
         end
         if (silent !== rd.silent) begin
            errors++;
            $display("%0t: silent mismatch, expected %0b actual %0b",
                     $time, rd.silent, silent);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ------------------------------------------------------------------
   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_tvalid  = 1'b0;
   logic                                req_tready;
   logic [2*scm_pkg::SAMPLE_BITS-1:0]   req_tdata   = '0;   // left, right
   logic [scm_pkg::FUNC_BITS-1:0]       req_tuser   = '0;   // func
   logic                                rsp_tvalid;
   logic                                rsp_tready  = 1'b0;
   logic [scm_pkg::OUT_BITS-1:0]        rsp_tdata;          // correlation
   logic                                rsp_tuser;          // silent
   logic                                csr_wr_en   = 1'b0;
   logic [scm_pkg::COEFF_BITS-1:0]      csr_wr_data = '0;   // smooth_coeff

   stereo_correlation_meter_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   meter_scoreboard sb = new();

   // Knobs shared by the two sides: no-gap stretches and the long receiver hold
   bit req_fast  = 1'b0;
   bit rsp_fast  = 1'b0;
   bit rsp_hold  = 1'b0;
   int n_holds   = 0;
   int n_coeffs  = 1;   // reset value counts as the first setting
   int stuck_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: any handshake on either side counts as progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: a random stall before each word, or the long hold when asked for
   initial begin : rsp_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold) begin
            stall    = HOLD_CYCLES;
            rsp_hold = 1'b0;
            n_holds++;
         end else begin
            stall = rsp_fast ? 0 : $urandom_range(0, 8);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_word(rsp_tdata, rsp_tuser);
      end
   end

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------
   // One input word; tvalid stays up across back-to-back words
   task automatic send_word(input scm_pkg::func_type f,
                            input logic signed [scm_pkg::SAMPLE_BITS-1:0] l,
                            input logic signed [scm_pkg::SAMPLE_BITS-1:0] r);
      int gap;
      gap = req_fast ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r, l};
      req_tuser  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(f, l, r);
   endtask

   // Stop offering and wait for every outstanding reading
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Only called with the core idle; the model switches at the same edge
   task automatic write_coeff(input logic [scm_pkg::COEFF_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.coeff = value;
      n_coeffs++;
   endtask

   // Full-range value most of the time, sometimes an extreme or a quiet one
   function automatic logic signed [scm_pkg::SAMPLE_BITS-1:0] draw_sample();
      logic signed [scm_pkg::SAMPLE_BITS-1:0] s;
      s = scm_pkg::SAMPLE_BITS'($urandom);
      case ($urandom_range(0, 9))
         0:       s = SAMPLE_MAX;
         1:       s = SAMPLE_MIN;
         2, 3, 4: s = s >>> $urandom_range(4, 20);
         default: ;
      endcase
      return s;
   endfunction

   // Runs of correlated pairs so the averages settle, with save/restore mixed in
   task automatic random_phase(input int n_words, input bit with_hold);
      pair_kind_type                          kind;
      int                                     run_left, roll;
      scm_pkg::func_type                      f;
      logic signed [scm_pkg::SAMPLE_BITS-1:0] l, r;
      run_left = 0;
      kind     = PAIR_FREE;
      for (int i = 0; i < n_words; i++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(5, 40);
            kind     = pair_kind_type'($urandom_range(0, 5));
            req_fast = ($urandom_range(0, 3) == 0);
            rsp_fast = ($urandom_range(0, 3) == 0);
         end
         run_left--;
         // receiver stops for a while; the sender keeps pushing so the core backs up
         if (with_hold && i == 20)
            rsp_hold = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 84)
            f = scm_pkg::FUNC_PROCESS;
         else if (roll < 90)
            f = scm_pkg::FUNC_SAVE;
         else if (roll < 96)
            f = scm_pkg::FUNC_RESTORE;
         else
            f = scm_pkg::FUNC_NOP;
         l = draw_sample();
         r = draw_sample();
         case (kind)
            PAIR_SAME:      r = l;
            PAIR_INVERT:    r = -l;
            PAIR_SCALED: begin
               r = l >>> $urandom_range(1, 12);
               if ($urandom_range(0, 1))
                  r = -r;
            end
            PAIR_NEAR:      r = l ^ scm_pkg::SAMPLE_BITS'($urandom_range(0, 255));
            PAIR_LEFT_ONLY: r = '0;
            default:        ;
         endcase
         send_word(f, l, r);
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : main_seq
      logic [scm_pkg::COEFF_BITS-1:0] coeff_plan[7];
      coeff_plan[0] = '0;                       // average follows the last sample
      coeff_plan[1] = '1;                       // heaviest smoothing
      coeff_plan[2] = 24'h800000;
      coeff_plan[3] = 24'hF00000;
      coeff_plan[4] = scm_pkg::COEFF_BITS'($urandom_range(0, 24'hFFFFFF));
      coeff_plan[5] = scm_pkg::COEFF_RESET;
      coeff_plan[6] = 24'h000001;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset coefficient
      send_word(scm_pkg::FUNC_RESTORE, '0, '0);          // restore before any save
      send_word(scm_pkg::FUNC_PROCESS, '0, '0);          // zero energy, silent
      send_word(scm_pkg::FUNC_PROCESS, SAMPLE_MAX, '0);  // right energy still zero
      send_word(scm_pkg::FUNC_RESTORE, '0, '0);
      send_word(scm_pkg::FUNC_PROCESS, '0, SAMPLE_MIN);  // left energy zero
      send_word(scm_pkg::FUNC_PROCESS, SAMPLE_MAX, SAMPLE_MAX);
      send_word(scm_pkg::FUNC_PROCESS, SAMPLE_MIN, SAMPLE_MIN);
      send_word(scm_pkg::FUNC_SAVE, SAMPLE_MAX, SAMPLE_MIN);
      send_word(scm_pkg::FUNC_PROCESS, SAMPLE_MAX, SAMPLE_MIN);
      send_word(scm_pkg::FUNC_PROCESS, SAMPLE_MIN, SAMPLE_MAX);
      send_word(scm_pkg::FUNC_PROCESS, 24'sd1, -24'sd1);
      send_word(scm_pkg::FUNC_PROCESS, -24'sd1, 24'sd1);
      send_word(scm_pkg::FUNC_NOP, SAMPLE_MIN, SAMPLE_MAX);  // unused code: state untouched
      send_word(scm_pkg::FUNC_RESTORE, '1, '1);
      send_word(scm_pkg::FUNC_PROCESS, 24'sd123456, -24'sd7654321);
      send_word(scm_pkg::FUNC_PROCESS, SAMPLE_MIN, '0);
      for (int k = 0; k < 8; k++)                   // back-to-back identical pairs
         send_word(scm_pkg::FUNC_PROCESS, SAMPLE_MAX, SAMPLE_MAX);

      // Random phases, one coefficient each; phase 2 carries the long hold
      foreach (coeff_plan[p]) begin
         drain();
         write_coeff(coeff_plan[p]);
         random_phase(PHASE_WORDS, p == 2);
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d readings: %0d sample pairs, %0d saves, %0d restores, %0d unused codes",
               sb.checked, sb.n_pairs, sb.n_saves, sb.n_restores, sb.n_unused);
      $display("%0d coefficient settings, %0d silent, %0d full scale, %0d negative, %0d long holds",
               n_coeffs, sb.n_silent, sb.n_full_scale, sb.n_negative, n_holds);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
